### hdl/rsfd_pkg.sv
// ----------------------------------------------------------------------------
// rsfd_pkg
// Shared types and constants of the radio sensor frame dispatcher.
// ----------------------------------------------------------------------------
`default_nettype none

package rsfd_pkg;

  localparam int FRAME_LEN = 12;
  localparam int CNT_W     = $clog2(FRAME_LEN + 1);
  localparam int ID_W      = 32;
  localparam int WORD_W    = 48;
  localparam int TDATA_W   = 88;

  localparam logic [7:0] START_BYTE = 8'h68;
  localparam logic [7:0] LEN_BYTE   = 8'h06;
  localparam logic [7:0] STOP_BYTE  = 8'h16;
  localparam logic [7:0] ALL_ONES   = 8'hFF;
  localparam logic [7:0] ACK_HEAD   = 8'hAA;
  localparam logic [7:0] RC_HEAD    = 8'hA6;
  localparam logic [7:0] RC_MASK_ON = 8'h53;
  localparam logic [7:0] RC_MASK_OFF = 8'h5C;
  localparam logic [7:0] TEMP_BASE  = 8'h61;
  localparam logic [7:0] TEMP_LAST  = 8'h63;
  localparam logic signed [7:0] TEMP_MAX = 8'sd125;
  localparam logic signed [7:0] TEMP_MIN = -8'sd85;

  localparam logic [7:0] ADDR_SW_FIRST   = 8'h01;
  localparam logic [7:0] ADDR_SW_LAST    = 8'h03;
  localparam logic [7:0] ADDR_LEAK_LAST  = 8'h07;
  localparam logic [3:0] NIB_ACK = 4'h0;
  localparam logic [3:0] NIB_RC  = 4'h2;
  localparam logic [7:0] DATA_ON  = 8'h01;
  localparam logic [7:0] DATA_OFF = 8'h02;
  localparam logic [7:0] LEAK_OFS = 8'h06;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_OWN   = 2'd1;
  localparam logic [1:0] KIND_BCAST = 2'd2;

  localparam logic [1:0] MEV_NONE = 2'd0;
  localparam logic [1:0] MEV_SET  = 2'd1;
  localparam logic [1:0] MEV_CLR  = 2'd2;

  localparam logic [1:0] UPD_NONE = 2'd0;
  localparam logic [1:0] UPD_SW   = 2'd1;
  localparam logic [1:0] UPD_LEAK = 2'd2;
  localparam logic [1:0] UPD_TEMP = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] addr;
    logic [7:0] data;
  } frame_t;

  typedef struct packed {
    logic [1:0]        frame_kind;
    logic [7:0]        dev_addr;
    logic [7:0]        dev_data;
    logic              reply_send;
    logic [WORD_W-1:0] reply_word;
    logic [1:0]        mask_event;
    logic              mask_on;
    logic [1:0]        update_kind;
    logic [3:0]        update_index;
    logic [7:0]        update_value;
  } result_t;

endpackage

`default_nettype wire

### hdl/radio_sensor_frame_dispatcher.sv
// ----------------------------------------------------------------------------
// radio_sensor_frame_dispatcher
// Path: the input register, then window check and command decode into the
//   result register, which drives out_tvalid and out_tdata.
// Throughput: one byte per cycle while out_tready allows; the window and mask
//   registers update in the same cycle a byte moves from input to result.
// Reset (rst_n low, synchronous): window empty, mask off, module id 0.
// ----------------------------------------------------------------------------
`default_nettype none

module radio_sensor_frame_dispatcher (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output      logic                         in_tready,
  input  wire logic [7:0]                   in_tdata,   // rx_byte
  input  wire logic                         in_tuser,   // burst_start
  output      logic                         out_tvalid,
  input  wire logic                         out_tready,
  // dev_addr, dev_data, reply_send, reply_word, mask_event, mask_on,
  // update_kind, update_index, update_value, zero pad
  output      logic [rsfd_pkg::TDATA_W-1:0] out_tdata,
  output      logic [1:0]                   out_tuser,  // frame_kind
  input  wire logic                         cfg_valid,
  output      logic                         cfg_ready,
  input  wire logic [rsfd_pkg::ID_W-1:0]    cfg_data    // module_id
);

  logic [7:0]                s1_byte_r;
  logic                      s1_burst_r;
  logic                      s1_valid_r;
  logic                      out_valid_r;
  rsfd_pkg::result_t         out_r;
  rsfd_pkg::result_t         result;
  rsfd_pkg::frame_t          frame;
  logic [rsfd_pkg::ID_W-1:0] module_id_r;
  logic                      out_adv;
  logic                      step;
  logic                      in_xfer;

  assign out_adv   = !out_valid_r || out_tready;
  assign step      = s1_valid_r && out_adv;
  assign in_tready = !s1_valid_r || out_adv;
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      module_id_r <= '0;
    end else if (cfg_valid) begin
      module_id_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (step) begin
        s1_valid_r <= 1'b0;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r  <= in_tdata;
      s1_burst_r <= in_tuser;
    end
    if (step) begin
      out_r <= result;
    end
  end

  rsfd_window u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .rx_byte     (s1_byte_r),
    .burst_start (s1_burst_r),
    .module_id   (module_id_r),
    .frame       (frame)
  );

  rsfd_cmd u_cmd (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .frame     (frame),
    .module_id (module_id_r),
    .result    (result)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.frame_kind;
  assign out_tdata  = {6'b0, out_r.update_value, out_r.update_index, out_r.update_kind,
                       out_r.mask_on, out_r.mask_event, out_r.reply_word,
                       out_r.reply_send, out_r.dev_data, out_r.dev_addr};

endmodule

`default_nettype wire

### hdl/rsfd_window.sv
// ----------------------------------------------------------------------------
// rsfd_window
// Sliding byte window with frame header, id and checksum match.
// ----------------------------------------------------------------------------
`default_nettype none

module rsfd_window (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     step,
  input  wire logic [7:0]               rx_byte,
  input  wire logic                     burst_start,
  input  wire logic [rsfd_pkg::ID_W-1:0] module_id,
  output rsfd_pkg::frame_t              frame
);

  localparam int LAST = rsfd_pkg::FRAME_LEN - 1;

  logic [7:0]                 win_r   [rsfd_pkg::FRAME_LEN];
  logic [7:0]                 win_nxt [rsfd_pkg::FRAME_LEN];
  logic [7:0]                 full_w  [rsfd_pkg::FRAME_LEN];
  logic [rsfd_pkg::CNT_W-1:0] cnt_r, cnt_nxt, cnt_eff;
  logic                       full;
  logic                       hdr_ok;
  logic [7:0]                 sum;
  logic [rsfd_pkg::ID_W-1:0]  id_field;
  logic                       own_ok, bc_ok;
  logic [1:0]                 kind;

  always_comb begin
    if (burst_start || cnt_r >= rsfd_pkg::CNT_W'(rsfd_pkg::FRAME_LEN)) begin
      cnt_eff = '0;
    end else begin
      cnt_eff = cnt_r;
    end
    full = (cnt_eff == rsfd_pkg::CNT_W'(LAST));
  end

  always_comb begin
    for (int i = 0; i < rsfd_pkg::FRAME_LEN; i++) begin
      full_w[i] = (i == LAST) ? rx_byte : win_r[i];
    end
    sum = '0;
    for (int i = 4; i < 10; i++) begin
      sum = sum + full_w[i];
    end
    hdr_ok = (full_w[0] == rsfd_pkg::START_BYTE) && (full_w[1] == rsfd_pkg::LEN_BYTE) &&
             (full_w[2] == rsfd_pkg::LEN_BYTE) && (full_w[3] == rsfd_pkg::START_BYTE) &&
             (full_w[LAST] == rsfd_pkg::STOP_BYTE) && (sum == full_w[10]);
    id_field = {full_w[4], full_w[5], full_w[6], full_w[7]};
    own_ok   = hdr_ok && (id_field == module_id);
    bc_ok    = hdr_ok && (id_field == {4{rsfd_pkg::ALL_ONES}});
    priority if (!full) begin
      kind = rsfd_pkg::KIND_NONE;
    end else if (own_ok) begin
      kind = rsfd_pkg::KIND_OWN;
    end else if (bc_ok) begin
      kind = rsfd_pkg::KIND_BCAST;
    end else begin
      kind = rsfd_pkg::KIND_NONE;
    end
  end

  always_comb begin
    frame.kind = kind;
    frame.addr = (kind != rsfd_pkg::KIND_NONE) ? full_w[8] : '0;
    frame.data = (kind != rsfd_pkg::KIND_NONE) ? full_w[9] : '0;
  end

  // full window: a match empties it, a miss drops the oldest byte
  always_comb begin
    for (int i = 0; i < rsfd_pkg::FRAME_LEN; i++) begin
      win_nxt[i] = win_r[i];
    end
    cnt_nxt = cnt_eff + 1'b1;
    if (full) begin
      if (kind != rsfd_pkg::KIND_NONE) begin
        cnt_nxt = '0;
      end else begin
        for (int i = 0; i < LAST; i++) begin
          win_nxt[i] = full_w[i + 1];
        end
        win_nxt[LAST] = '0;
        cnt_nxt = rsfd_pkg::CNT_W'(LAST);
      end
    end else begin
      for (int i = 0; i < rsfd_pkg::FRAME_LEN; i++) begin
        if (i == int'(cnt_eff)) begin
          win_nxt[i] = rx_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (step) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      win_r <= win_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/rsfd_cmd.sv
// ----------------------------------------------------------------------------
// rsfd_cmd
// Command decode of a matched frame: replies, mask flag and status updates.
// ----------------------------------------------------------------------------
`default_nettype none

module rsfd_cmd (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      step,
  input  wire rsfd_pkg::frame_t          frame,
  input  wire logic [rsfd_pkg::ID_W-1:0] module_id,
  output rsfd_pkg::result_t              result
);

  logic mask_r, mask_nxt;
  logic is_own;
  logic is_frame;
  logic signed [7:0] temp;

  always_comb begin
    is_own   = (frame.kind == rsfd_pkg::KIND_OWN);
    is_frame = (frame.kind != rsfd_pkg::KIND_NONE);
    temp     = $signed(frame.data);
    mask_nxt = mask_r;

    result.frame_kind   = frame.kind;
    result.dev_addr     = frame.addr;
    result.dev_data     = frame.data;
    result.reply_send   = 1'b0;
    result.reply_word   = '0;
    result.mask_event   = rsfd_pkg::MEV_NONE;
    result.update_kind  = rsfd_pkg::UPD_NONE;
    result.update_index = '0;
    result.update_value = '0;

    if (is_own && frame.addr[7:4] == rsfd_pkg::NIB_ACK) begin
      result.reply_send = 1'b1;
      result.reply_word = {rsfd_pkg::ACK_HEAD, module_id, frame.addr[3:0], 4'hF};
    end else if (is_frame && frame.addr[7:4] == rsfd_pkg::NIB_RC) begin
      if (frame.data == rsfd_pkg::RC_MASK_ON) begin
        result.reply_send = 1'b1;
        result.reply_word = {rsfd_pkg::RC_HEAD, {4{rsfd_pkg::ALL_ONES}}, rsfd_pkg::RC_MASK_ON};
        result.mask_event = rsfd_pkg::MEV_SET;
        mask_nxt          = 1'b1;
      end else if (frame.data == rsfd_pkg::RC_MASK_OFF) begin
        result.reply_send = 1'b1;
        result.reply_word = {rsfd_pkg::RC_HEAD, {4{rsfd_pkg::ALL_ONES}}, rsfd_pkg::RC_MASK_OFF};
        result.mask_event = rsfd_pkg::MEV_CLR;
        mask_nxt          = 1'b0;
      end
    end

    if (is_own) begin
      if (frame.addr >= rsfd_pkg::ADDR_SW_FIRST && frame.addr <= rsfd_pkg::ADDR_LEAK_LAST &&
          (frame.data == rsfd_pkg::DATA_ON || frame.data == rsfd_pkg::DATA_OFF)) begin
        if (frame.addr <= rsfd_pkg::ADDR_SW_LAST) begin
          result.update_kind  = rsfd_pkg::UPD_SW;
          result.update_index = 4'(frame.addr - rsfd_pkg::ADDR_SW_FIRST);
        end else begin
          result.update_kind  = rsfd_pkg::UPD_LEAK;
          result.update_index = 4'(frame.addr + rsfd_pkg::LEAK_OFS);
        end
        result.update_value = (frame.data == rsfd_pkg::DATA_ON) ? 8'd1 : 8'd0;
      end else if (frame.addr >= rsfd_pkg::TEMP_BASE && frame.addr <= rsfd_pkg::TEMP_LAST) begin
        if (temp < rsfd_pkg::TEMP_MAX && temp > rsfd_pkg::TEMP_MIN) begin
          result.update_kind  = rsfd_pkg::UPD_TEMP;
          result.update_index = 4'(frame.addr - rsfd_pkg::TEMP_BASE);
          result.update_value = frame.data;
        end
      end
    end

    result.mask_on = mask_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= 1'b0;
    end else if (step) begin
      mask_r <= mask_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/rsfd_checker.sv
// ----------------------------------------------------------------------------
// rsfd_checker
// Port-level checks of the frame dispatcher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rsfd_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         out_tvalid,
  input wire logic                         out_tready,
  input wire logic [rsfd_pkg::TDATA_W-1:0] out_tdata,
  input wire logic [1:0]                   out_tuser
);

  logic                       reply_send;
  logic [rsfd_pkg::WORD_W-1:0] reply_word;
  logic [1:0]                 mask_event;
  logic                       mask_on;
  logic [1:0]                 update_kind;

  assign reply_send  = out_tdata[16];
  assign reply_word  = out_tdata[64:17];
  assign mask_event  = out_tdata[66:65];
  assign mask_on     = out_tdata[67];
  assign update_kind = out_tdata[69:68];

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_no_frame_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == rsfd_pkg::KIND_NONE |->
      out_tdata[15:0] == 16'd0 && !reply_send && update_kind == rsfd_pkg::UPD_NONE)
    else $error("action without a frame");

  a_reply_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !reply_send |-> reply_word == '0 && mask_event == rsfd_pkg::MEV_NONE)
    else $error("reply word or mask event without reply");

  a_mask_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (mask_event == rsfd_pkg::MEV_SET || mask_event == rsfd_pkg::MEV_CLR) |->
      mask_on == (mask_event == rsfd_pkg::MEV_SET))
    else $error("mask flag disagrees with mask event");

  a_bcast_no_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == rsfd_pkg::KIND_BCAST |-> update_kind == rsfd_pkg::UPD_NONE)
    else $error("status update on broadcast frame");

endmodule

bind radio_sensor_frame_dispatcher rsfd_checker u_rsfd_checker (.*);

`default_nettype wire

### tb/radio_sensor_frame_dispatcher_test.sv
// ----------------------------------------------------------------------------
// radio_sensor_frame_dispatcher_test
// Streams received bytes through the dispatcher and checks every result
// against a cycle-free predictor of the sliding frame window: own-id and
// broadcast frames, acknowledge and remote-control replies, mask tracking,
// status and temperature updates, burst restarts, corrupted and shifted
// frames. Both stream sides idle at random, with one quiet phase and one long
// receiver hold-off. The module id is rewritten between phases while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module radio_sensor_frame_dispatcher_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rsfd_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 170;
  localparam int TIMEOUT_NS  = 4_000_000;

  class frame_scoreboard;
    logic [7:0]     win [FRAME_LEN];
    int unsigned    fill;
    bit             mask;
    logic [ID_W-1:0] module_id;
    result_t        pending [$];
    int unsigned    errors;
    int unsigned    results_seen;

    function new();
      foreach (win[k]) win[k] = '0;
      fill = 0;
      mask = 1'b0;
      module_id = '0;
      errors = 0;
      results_seen = 0;
    endfunction

    function bit frame_matches(logic [ID_W-1:0] id);
      logic [7:0] sum;
      sum = '0;
      if (win[0] != START_BYTE || win[1] != LEN_BYTE || win[2] != LEN_BYTE ||
          win[3] != START_BYTE || win[11] != STOP_BYTE)
        return 1'b0;
      if ({win[4], win[5], win[6], win[7]} != id)
        return 1'b0;
      for (int k = 4; k < 10; k++)
        sum = sum + win[k];
      return sum == win[10];
    endfunction

    function void note_input(logic [7:0] rx, logic burst);
      result_t r;
      logic [7:0] a;
      logic [7:0] d;
      logic signed [7:0] t;
      r = '0;
      if (burst)
        fill = 0;
      if (fill >= FRAME_LEN)
        fill = 0;
      win[fill] = rx;
      fill++;
      if (fill == FRAME_LEN) begin
        if (frame_matches(module_id))
          r.frame_kind = KIND_OWN;
        else if (frame_matches('1))
          r.frame_kind = KIND_BCAST;
        if (r.frame_kind != KIND_NONE) begin
          a = win[8];
          d = win[9];
          t = d;
          r.dev_addr = a;
          r.dev_data = d;
          if (r.frame_kind == KIND_OWN && a[7:4] == NIB_ACK) begin
            r.reply_send = 1'b1;
            r.reply_word = {ACK_HEAD, module_id, a[3:0], 4'hF};
          end else if (a[7:4] == NIB_RC) begin
            if (d == RC_MASK_ON) begin
              r.reply_send = 1'b1;
              r.reply_word = {RC_HEAD, {4{ALL_ONES}}, RC_MASK_ON};
              r.mask_event = MEV_SET;
              mask = 1'b1;
            end else if (d == RC_MASK_OFF) begin
              r.reply_send = 1'b1;
              r.reply_word = {RC_HEAD, {4{ALL_ONES}}, RC_MASK_OFF};
              r.mask_event = MEV_CLR;
              mask = 1'b0;
            end
          end
          if (r.frame_kind == KIND_OWN) begin
            if (a >= ADDR_SW_FIRST && a <= ADDR_LEAK_LAST &&
                (d == DATA_ON || d == DATA_OFF)) begin
              r.update_kind  = (a <= ADDR_SW_LAST) ? UPD_SW : UPD_LEAK;
              r.update_index = (a <= ADDR_SW_LAST) ? 4'(a - 8'd1) : 4'(a + LEAK_OFS);
              r.update_value = (d == DATA_ON) ? 8'd1 : 8'd0;
            end else if (a >= TEMP_BASE && a <= TEMP_LAST) begin
              if (t < TEMP_MAX && t > TEMP_MIN) begin
                r.update_kind  = UPD_TEMP;
                r.update_index = 4'(a - TEMP_BASE);
                r.update_value = d;
              end
            end
          end
          fill = 0;
        end else begin
          for (int k = 0; k < FRAME_LEN - 1; k++)
            win[k] = win[k + 1];
          win[FRAME_LEN - 1] = '0;
          fill = FRAME_LEN - 1;
        end
      end
      r.mask_on = mask;
      pending.push_back(r);
    endfunction

    task report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s at result %0d: got %h expected %h",
               field, results_seen, got, want);
      errors++;
    endtask

    task check_result(logic [1:0] kind, logic [TDATA_W-1:0] tdata);
      result_t got;
      result_t want;
      got.frame_kind = kind;
      {got.update_value, got.update_index, got.update_kind, got.mask_on,
       got.mask_event, got.reply_word, got.reply_send, got.dev_data,
       got.dev_addr} = tdata[81:0];
      if (pending.size() == 0) begin
        report_mismatch("unexpected result", tdata[63:0], '0);
      end else begin
        want = pending.pop_front();
        if (got.frame_kind !== want.frame_kind)
          report_mismatch("frame_kind", 64'(got.frame_kind), 64'(want.frame_kind));
        if (got.dev_addr !== want.dev_addr)
          report_mismatch("dev_addr", 64'(got.dev_addr), 64'(want.dev_addr));
        if (got.dev_data !== want.dev_data)
          report_mismatch("dev_data", 64'(got.dev_data), 64'(want.dev_data));
        if (got.reply_send !== want.reply_send)
          report_mismatch("reply_send", 64'(got.reply_send), 64'(want.reply_send));
        if (got.reply_word !== want.reply_word)
          report_mismatch("reply_word", 64'(got.reply_word), 64'(want.reply_word));
        if (got.mask_event !== want.mask_event)
          report_mismatch("mask_event", 64'(got.mask_event), 64'(want.mask_event));
        if (got.mask_on !== want.mask_on)
          report_mismatch("mask_on", 64'(got.mask_on), 64'(want.mask_on));
        if (got.update_kind !== want.update_kind)
          report_mismatch("update_kind", 64'(got.update_kind), 64'(want.update_kind));
        if (got.update_index !== want.update_index)
          report_mismatch("update_index", 64'(got.update_index), 64'(want.update_index));
        if (got.update_value !== want.update_value)
          report_mismatch("update_value", 64'(got.update_value), 64'(want.update_value));
      end
      results_seen++;
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [TDATA_W-1:0]    out_tdata;
  logic [1:0]            out_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [ID_W-1:0]       cfg_data;

  frame_scoreboard sb = new();
  int unsigned     sent = 0;
  bit              quiet = 1'b0;
  bit              hold_go = 1'b0;
  int unsigned     hold_left = 0;
  logic [7:0]      temp_edges [7] = '{8'd125, 8'd124, 8'hAB, 8'hAC, 8'h7F, 8'h80, 8'h00};

  radio_sensor_frame_dispatcher u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_input(in_tdata, in_tuser);
      if (out_tvalid && out_tready)
        sb.check_result(out_tuser, out_tdata);
    end
  end

  // receiver: random back-pressure, one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_go && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_go = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready = 1'b0;
      end else begin
        out_tready = quiet || ($urandom_range(99) >= 9);
      end
    end
  end

  task automatic push_byte(input logic [7:0] rx, input logic burst);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 9) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = rx;
    in_tuser  = burst;
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  task automatic send_frame(input logic [ID_W-1:0] id, input logic [7:0] addr,
                            input logic [7:0] data, input bit first_burst,
                            input bit corrupt, input int cut);
    logic [7:0] fb [FRAME_LEN];
    fb[0] = START_BYTE;
    fb[1] = LEN_BYTE;
    fb[2] = LEN_BYTE;
    fb[3] = START_BYTE;
    {fb[4], fb[5], fb[6], fb[7]} = id;
    fb[8] = addr;
    fb[9] = data;
    fb[10] = fb[4] + fb[5] + fb[6] + fb[7] + fb[8] + fb[9];
    fb[11] = STOP_BYTE;
    // aborted prefix, then the frame restarts on a burst boundary
    for (int k = 0; k < cut; k++)
      push_byte(fb[k], k == 0 && $urandom_range(1));
    if (corrupt)
      fb[$urandom_range(FRAME_LEN - 1)] ^= 8'($urandom_range(1, 255));
    for (int k = 0; k < FRAME_LEN; k++)
      push_byte(fb[k], k == 0 && (first_burst || cut != 0));
  endtask

  task automatic random_frame();
    logic [ID_W-1:0] id;
    logic [7:0] addr;
    logic [7:0] data;
    int pick;
    pick = $urandom_range(99);
    if (pick < 60)
      id = sb.module_id;
    else if (pick < 85)
      id = '1;
    else
      id = $urandom;
    case ($urandom_range(5))
      0: begin
        addr = {NIB_ACK, 4'($urandom)};
        data = 8'($urandom);
      end
      1: begin
        addr = {NIB_RC, 4'($urandom)};
        pick = $urandom_range(3);
        data = (pick == 0) ? RC_MASK_ON : (pick == 1) ? RC_MASK_OFF : 8'($urandom);
      end
      2: begin
        addr = 8'($urandom_range(0, 8));
        data = 8'($urandom_range(0, 3));
      end
      3: begin
        addr = 8'($urandom_range(TEMP_BASE - 1, TEMP_LAST + 1));
        data = $urandom_range(1) ? temp_edges[$urandom_range(6)] : 8'($urandom);
      end
      default: begin
        addr = 8'($urandom);
        data = 8'($urandom);
      end
    endcase
    if ($urandom_range(99) < 20)
      repeat ($urandom_range(1, 4))
        push_byte($urandom_range(1) ? 8'($urandom) : START_BYTE, $urandom_range(99) < 10);
    send_frame(id, addr, data, 1'($urandom_range(1)), $urandom_range(99) < 12,
               ($urandom_range(99) < 8) ? int'($urandom_range(1, FRAME_LEN - 1)) : 0);
  endtask

  task automatic write_module_id(input logic [ID_W-1:0] id);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = id;
    do @(posedge clk); while (!cfg_ready);
    sb.module_id = id;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic settle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.pending.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [ID_W-1:0] id;
    int unsigned target;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_module_id($urandom);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(START_BYTE, 1'b0);
    send_frame(sb.module_id, 8'h0F, 8'hFF, 1'b1, 1'b0, 0);
    send_frame('1, {NIB_RC, 4'h0}, RC_MASK_ON, 1'b0, 1'b0, 0);
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: id = '0;
        1: id = '1;
        default: id = $urandom;
      endcase
      write_module_id(id);
      quiet   = (ph == 1);
      hold_go = (ph == 2);
      target  = sent + PHASE_ITEMS;
      while (sent < target)
        random_frame();
      settle();
    end

    if (sb.errors == 0) begin
      $display("PASS radio_sensor_frame_dispatcher");
    end else begin
      $display("FAIL radio_sensor_frame_dispatcher");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("FAIL radio_sensor_frame_dispatcher");
    $finish;
  end

endmodule

`default_nettype wire
